FILE: design/sesc_pkg.sv
// Shared types and constants for the stepper step-loss correction block.
// No dependencies; imported by the core, output stage and top level.
package sesc_pkg;

  // Item kinds on the input channel; the fourth code is unused.
  typedef enum logic [1:0] {
    ACT_STEP   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COUNT_W  = 32;

  // One result beat.
  typedef struct packed {
    logic                       step_pulse;
    logic                       direction_level;
    logic signed [COUNT_W-1:0]  pending_steps;
    logic signed [COUNT_W-1:0]  measured_position;
  } result_t;

endpackage

FILE: design/sesc_if.sv
// Valid/ready channel interfaces for the step-loss correction block.
// Depends on sesc_pkg for field widths.
interface sesc_in_if #(
  parameter int unsigned ENC_W = 12
);
  import sesc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic                 step_direction;
  logic [ENC_W-1:0]     raw_angle;

  modport source (output valid, action, step_direction, raw_angle, input ready);
  modport sink   (input valid, action, step_direction, raw_angle, output ready);
endinterface

interface sesc_out_if;
  import sesc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       step_pulse;
  logic                       direction_level;
  logic signed [COUNT_W-1:0]  pending_steps;
  logic signed [COUNT_W-1:0]  measured_position;

  modport source (output valid, step_pulse, direction_level, pending_steps,
                  measured_position, input ready);
  modport sink   (input valid, step_pulse, direction_level, pending_steps,
                  measured_position, output ready);
endinterface

FILE: design/stepper_encoder_step_loss_correction.sv
// Closed-loop stepper step-loss correction. Every input beat (step request,
// encoder sample or correction tick) yields exactly one result beat. The
// block takes one beat per clock while the result channel is not stalled: a
// beat lands in the input register, the core works it out combinationally
// and updates its state as the beat moves into the result register, from
// which the result beat is offered. A stalled result register holds the
// input stage, which still takes one more beat while the result waits.
// home_offset is written through cfg_we_i/cfg_wdata_i and should only
// change while no beat is in flight. Reset clears all tracking and
// correction state.
// Depends on sesc_pkg, sesc_if, sesc_in_reg, sesc_core and sesc_out_reg.
module stepper_encoder_step_loss_correction #(
  parameter int unsigned STEPS_PER_TURN = 3200,
  parameter int unsigned ENCODER_BITS   = 12,
  parameter int unsigned TICK_DIVIDE    = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ENCODER_BITS-1:0] cfg_wdata_i,
  sesc_in_if.sink                 item_i,
  sesc_out_if.source              result_o
);
  import sesc_pkg::*;

  // Input stage outputs
  logic                    s1_vld;
  logic [ACTION_W-1:0]     s1_action;
  logic                    s1_dir;
  logic [ENCODER_BITS-1:0] s1_raw;

  // Handshake between stages: adv means the result register can load.
  logic    adv;
  logic    fire;
  result_t res;

  assign fire = s1_vld && adv;

  sesc_in_reg #(
    .ENC_W (ENCODER_BITS)
  ) u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .adv_i    (adv),
    .vld_o    (s1_vld),
    .action_o (s1_action),
    .dir_o    (s1_dir),
    .raw_o    (s1_raw)
  );

  // Tracking state only moves when a beat actually passes into the result register; home_offset loads on cfg_we_i.
  sesc_core #(
    .STEPS_PER_TURN (STEPS_PER_TURN),
    .ENCODER_BITS   (ENCODER_BITS),
    .TICK_DIVIDE    (TICK_DIVIDE)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .action_i    (s1_action),
    .dir_i       (s1_dir),
    .raw_i       (s1_raw),
    .res_o       (res)
  );

  sesc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (s1_vld),
    .res_i    (res),
    .adv_o    (adv),
    .result_o (result_o)
  );
endmodule

FILE: design/sesc_in_reg.sv
// Input register stage: captures one beat from the input channel.
// Depends on sesc_pkg and sesc_in_if.
module sesc_in_reg #(
  parameter int unsigned ENC_W = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sesc_in_if.sink                       item_i,
  input  logic                          adv_i,
  output logic                          vld_o,
  output logic [sesc_pkg::ACTION_W-1:0] action_o,
  output logic                          dir_o,
  output logic [ENC_W-1:0]              raw_o
);
  import sesc_pkg::*;

  logic                vld_q;
  logic [ACTION_W-1:0] action_q;
  logic                dir_q;
  logic [ENC_W-1:0]    raw_q;
  logic                take;

  // Free when empty or when the held beat moves on this cycle.
  assign item_i.ready = !vld_q || adv_i;
  assign take         = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (item_i.ready) begin
      vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      action_q <= item_i.action;
      dir_q    <= item_i.step_direction;
      raw_q    <= item_i.raw_angle;
    end
  end

  assign vld_o    = vld_q;
  assign action_o = action_q;
  assign dir_o    = dir_q;
  assign raw_o    = raw_q;
endmodule

FILE: design/sesc_core.sv
// Position tracking and correction state; computes one result per beat.
// Depends on sesc_pkg.
module sesc_core #(
  parameter int unsigned STEPS_PER_TURN = 3200,
  parameter int unsigned ENCODER_BITS   = 12,
  parameter int unsigned TICK_DIVIDE    = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ENCODER_BITS-1:0]       cfg_wdata_i,
  input  logic                          fire_i,
  input  logic [sesc_pkg::ACTION_W-1:0] action_i,
  input  logic                          dir_i,
  input  logic [ENCODER_BITS-1:0]       raw_i,
  output sesc_pkg::result_t             res_o
);
  import sesc_pkg::*;

  localparam int unsigned EB      = ENCODER_BITS;
  localparam int unsigned TURN_W  = COUNT_W - EB;
  localparam int unsigned SPT_LOG = $clog2(STEPS_PER_TURN);
  localparam int unsigned MAXSH   = (EB > SPT_LOG) ? EB : SPT_LOG;
  localparam int unsigned ERR_W   = 34 + MAXSH;
  localparam int unsigned PRE_W   = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
  localparam longint      UNITS   = longint'(STEPS_PER_TURN) << EB;
  localparam longint      THRESH  = UNITS / 360;

  localparam logic signed [ERR_W-1:0] THR_X   = ERR_W'(THRESH);
  localparam logic signed [ERR_W-1:0] SPT_X   = ERR_W'(STEPS_PER_TURN);
  localparam logic signed [ERR_W-1:0] BIAS_X  = ERR_W'((longint'(1) << EB) - 1);
  localparam logic signed [EB:0]      HALF_X  = (EB+1)'(longint'(1) << (EB - 1));
  localparam logic [PRE_W-1:0]        PRE_END = PRE_W'(TICK_DIVIDE - 1);

  logic [EB-1:0]             home_q;
  logic [COUNT_W-1:0]        cmd_q, cmd_d;
  logic [EB-1:0]             prev_q, prev_d;
  logic [TURN_W-1:0]         turn_q, turn_d;
  logic signed [COUNT_W-1:0] corr_q, corr_d;
  logic [PRE_W-1:0]          pre_q, pre_d;
  logic                      armed_q, armed_d;
  logic                      dir_q, dir_d;
  logic                      pulse;

  logic [EB-1:0]             off;
  logic signed [EB:0]        dlt;
  logic [TURN_W-1:0]         turn_new;
  logic signed [COUNT_W-1:0] meas_new;
  logic signed [ERR_W-1:0]   err, quot;

  // Sample path: offset, wrap tracking, error in 1/(SPT*2^EB) turn units.
  always_comb begin
    off      = raw_i - home_q;
    dlt      = $signed({1'b0, prev_q}) - $signed({1'b0, off});
    turn_new = turn_q;
    if (dlt < -HALF_X) begin
      turn_new = turn_q - TURN_W'(1);
    end else if (dlt > HALF_X) begin
      turn_new = turn_q + TURN_W'(1);
    end
    meas_new = $signed({turn_new, off});
    err      = (ERR_W'($signed(cmd_q)) <<< EB) - ERR_W'(meas_new) * SPT_X;
    // truncate toward zero
    quot     = (err + (err[ERR_W-1] ? BIAS_X : '0)) >>> EB;
  end

  always_comb begin
    cmd_d   = cmd_q;
    prev_d  = prev_q;
    turn_d  = turn_q;
    corr_d  = corr_q;
    pre_d   = pre_q;
    armed_d = armed_q;
    dir_d   = dir_q;
    pulse   = 1'b0;
    unique case (action_i)
      ACT_STEP: begin
        cmd_d = dir_i ? cmd_q - COUNT_W'(1) : cmd_q + COUNT_W'(1);
        if (corr_q == '0) begin
          dir_d = dir_i;
          pulse = 1'b1;
        end
      end
      ACT_SAMPLE: begin
        prev_d = off;
        turn_d = turn_new;
        if (err > THR_X) begin
          corr_d  = quot[COUNT_W-1:0];
          dir_d   = 1'b0;
          armed_d = 1'b1;
        end else if (err < -THR_X) begin
          corr_d  = quot[COUNT_W-1:0];
          dir_d   = 1'b1;
          armed_d = 1'b1;
        end else begin
          corr_d  = '0;
          armed_d = 1'b0;
        end
      end
      ACT_TICK: begin
        if (armed_q) begin
          if (pre_q < PRE_END) begin
            pre_d = pre_q + PRE_W'(1);
          end else if (corr_q != '0) begin
            pulse  = 1'b1;
            corr_d = corr_q[COUNT_W-1] ? corr_q + COUNT_W'(1) : corr_q - COUNT_W'(1);
            pre_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q  <= '0;
      cmd_q   <= '0;
      prev_q  <= '0;
      turn_q  <= '0;
      corr_q  <= '0;
      pre_q   <= '0;
      armed_q <= 1'b0;
      dir_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        home_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        cmd_q   <= cmd_d;
        prev_q  <= prev_d;
        turn_q  <= turn_d;
        corr_q  <= corr_d;
        pre_q   <= pre_d;
        armed_q <= armed_d;
        dir_q   <= dir_d;
      end
    end
  end

  // Measured total is the turn count above the last offset angle.
  assign res_o.step_pulse        = pulse;
  assign res_o.direction_level   = dir_d;
  assign res_o.pending_steps     = corr_d;
  assign res_o.measured_position = $signed({turn_d, prev_d});
endmodule

FILE: design/sesc_out_reg.sv
// Result register stage driving the output channel.
// Depends on sesc_pkg and sesc_out_if.
module sesc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  sesc_pkg::result_t res_i,
  output logic              adv_o,
  sesc_out_if.source        result_o
);
  import sesc_pkg::*;

  logic    vld_q;
  result_t res_q;

  assign adv_o = !vld_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && vld_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid             = vld_q;
  assign result_o.step_pulse        = res_q.step_pulse;
  assign result_o.direction_level   = res_q.direction_level;
  assign result_o.pending_steps     = res_q.pending_steps;
  assign result_o.measured_position = res_q.measured_position;
endmodule
